@@ sv/de_bruijn_sequence_generator_assert.svh @@
// Assertion macros for the de Bruijn sequence generator datapath.
// No dependencies; the bodies compile away when SYNTHESIS is defined.
`ifndef DE_BRUIJN_SEQUENCE_GENERATOR_ASSERT_SVH
`define DE_BRUIJN_SEQUENCE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge outside reset
`define DBSG_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent
`define DBSG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define DBSG_ASSERT_ALWAYS(label, clk, rst, cond)
`define DBSG_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

@@ sv/dbsg_pkg.sv @@
// Shared constants and controller/datapath interface types for the
// de Bruijn sequence generator. No dependencies.
`timescale 1ns / 1ps

package dbsg_pkg;

   // Configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYMBOL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WORD_LENGTH  = 2'd1;

   localparam logic [CSR_DATA_BITS-1:0] SYMBOL_COUNT_RESET = 5'd2;
   localparam logic [CSR_DATA_BITS-1:0] WORD_LENGTH_RESET  = 5'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic begin_seq;   // reset prenecklace state, start clearing digits
      logic clear_step;  // write one zero digit
      logic read_sym;    // read digit at the read position
      logic emit;        // load the output register, advance read position
      logic scan_start;  // start searching for the next prenecklace
      logic scan_rd;     // read digit i
      logic scan_chk;    // test digit i, increment it or step down
      logic copy_rd;     // read periodic source digit
      logic copy_wr;     // write copied digit
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic at_start;    // next transaction starts the sequence
      logic clear_done;  // last digit of the clearing pass
      logic out_free;    // output register can take a result
      logic wrap;        // read position is at the end of the period
      logic last_word;   // wrap on the final prenecklace
      logic digit_less;  // scanned digit is below the top symbol
      logic scan_first;  // scan is at the first digit
      logic no_copy;     // incremented digit is the last digit
      logic copy_done;   // copy is at the last digit
      logic divisible;   // word length is a multiple of the new period
   } status_type;

endpackage

@@ sv/dbsg_ctrl.sv @@
// Controller state machine for the de Bruijn sequence generator.
// Depends on dbsg_pkg for the command and status types.
`timescale 1ns / 1ps

module dbsg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   input  dbsg_pkg::status_type sts,
   output dbsg_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_EMIT,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_COPY_RD,
      ST_COPY_WR
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // Decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_restart || sts.at_start) begin
                  cmd.begin_seq = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_sym = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            // hold the digit until the output register frees up
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.wrap && !sts.last_word) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            priority if (sts.digit_less) begin
               state_in = sts.no_copy ? ST_IDLE : ST_COPY_RD;
            end else if (sts.scan_first) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
            if (sts.copy_done) begin
               // skip prenecklaces whose period does not divide the word length
               if (sts.divisible) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_RD;
               end
            end else begin
               state_in = ST_COPY_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/dbsg_dpath.sv @@
// Datapath of the de Bruijn sequence generator: configuration, digit
// memory, prenecklace counters and output register. Depends on dbsg_pkg
// and de_bruijn_sequence_generator_assert.svh.
`timescale 1ns / 1ps
`include "de_bruijn_sequence_generator_assert.svh"

module dbsg_dpath #(
   parameter int MAX_WORD_LENGTH = 16,
   parameter int SYMBOL_BITS     = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [dbsg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dbsg_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  dbsg_pkg::cmd_type                  cmd,
   output dbsg_pkg::status_type               sts,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [SYMBOL_BITS-1:0]             rsp_symbol,
   output logic                               rsp_last
);

   localparam int CW = $clog2(MAX_WORD_LENGTH + 1);
   localparam int IW = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1;
   localparam int DB = dbsg_pkg::CSR_DATA_BITS;
   localparam int LW = (CW > DB) ? CW : DB;
   localparam int AW = (SYMBOL_BITS + 1 > DB) ? SYMBOL_BITS + 1 : DB;

   logic [DB-1:0]          symbol_count_ff;
   logic [DB-1:0]          word_length_ff;
   logic                   at_start_ff;
   logic [CW-1:0]          period_ff;
   logic [CW-1:0]          rpos_ff;
   logic                   top_word_ff;
   logic [CW-1:0]          i_ff;
   logic [CW-1:0]          j_ff;
   logic [IW-1:0]          m_ff;
   logic [SYMBOL_BITS-1:0] rd_data_ff;
   logic                   rsp_valid_ff;
   logic [SYMBOL_BITS-1:0] rsp_symbol_ff;
   logic                   rsp_last_ff;

   logic [SYMBOL_BITS-1:0] digit_mem [MAX_WORD_LENGTH];

   logic [LW-1:0]          wl_ext;
   logic [CW-1:0]          k_eff;
   logic [AW-1:0]          as_ext;
   logic [AW-1:0]          as_cap;
   logic [AW-1:0]          a_eff;
   logic [SYMBOL_BITS-1:0] top_sym;
   logic [SYMBOL_BITS-1:0] digit_inc;
   logic [IW-1:0]          i_idx;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic [SYMBOL_BITS-1:0] wr_data;

   // Clamp the word length into 1..MAX_WORD_LENGTH
   assign wl_ext = LW'(word_length_ff);
   always_comb begin
      priority if (wl_ext == '0) begin
         k_eff = CW'(1);
      end else if (wl_ext > LW'(MAX_WORD_LENGTH)) begin
         k_eff = CW'(MAX_WORD_LENGTH);
      end else begin
         k_eff = wl_ext[CW-1:0];
      end
   end

   // Clamp the alphabet into 2..2^SYMBOL_BITS, keep its top symbol
   assign as_ext = AW'(symbol_count_ff);
   assign as_cap = AW'(1) << SYMBOL_BITS;
   always_comb begin
      priority if (as_ext < AW'(2)) begin
         a_eff = AW'(2);
      end else if (as_ext > as_cap) begin
         a_eff = as_cap;
      end else begin
         a_eff = as_ext;
      end
   end
   assign top_sym   = SYMBOL_BITS'(a_eff - AW'(1));
   assign digit_inc = rd_data_ff + SYMBOL_BITS'(1);
   assign i_idx     = IW'(i_ff - CW'(1));

   // Select memory read and write ports
   always_comb begin
      rd_en   = cmd.read_sym || cmd.scan_rd || cmd.copy_rd;
      rd_addr = m_ff;
      if (cmd.read_sym) begin
         rd_addr = IW'(rpos_ff - CW'(1));
      end else if (cmd.scan_rd) begin
         rd_addr = i_idx;
      end
      wr_en   = 1'b0;
      wr_addr = IW'(j_ff - CW'(1));
      wr_data = rd_data_ff;
      if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_data = '0;
      end else if (cmd.scan_chk && (rd_data_ff < top_sym)) begin
         wr_en   = 1'b1;
         wr_addr = i_idx;
         wr_data = digit_inc;
      end else if (cmd.copy_wr) begin
         wr_en = 1'b1;
      end
   end

   // Digit memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   // Configuration and sequence control state
   always_ff @(posedge clock) begin
      if (reset) begin
         symbol_count_ff <= dbsg_pkg::SYMBOL_COUNT_RESET;
         word_length_ff  <= dbsg_pkg::WORD_LENGTH_RESET;
         at_start_ff     <= 1'b1;
         period_ff       <= CW'(1);
         rpos_ff         <= CW'(1);
         top_word_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // drop the result once the receiver takes it
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.begin_seq) begin
            at_start_ff <= 1'b0;
            period_ff   <= CW'(1);
            rpos_ff     <= CW'(1);
            top_word_ff <= 1'b0;
         end

         // advance the read position, restart after the final symbol
         if (cmd.emit) begin
            if (rpos_ff == period_ff) begin
               rpos_ff <= CW'(1);
               if (top_word_ff) begin
                  at_start_ff <= 1'b1;
               end
            end else begin
               rpos_ff <= rpos_ff + CW'(1);
            end
         end

         // take the new period, or give up when no prenecklace remains
         if (cmd.scan_chk) begin
            if (rd_data_ff < top_sym) begin
               period_ff   <= i_ff;
               top_word_ff <= (i_ff == CW'(1)) && (digit_inc == top_sym);
            end else if (i_ff == CW'(1)) begin
               at_start_ff <= 1'b1;
            end
         end

         if (csr_we) begin
            if (csr_index == dbsg_pkg::CSR_SYMBOL_COUNT) begin
               symbol_count_ff <= csr_wdata;
               at_start_ff     <= 1'b1;
            end else if (csr_index == dbsg_pkg::CSR_WORD_LENGTH) begin
               word_length_ff <= csr_wdata;
               at_start_ff    <= 1'b1;
            end
         end
      end
   end

   // Scan and copy counters
   always_ff @(posedge clock) begin
      if (cmd.begin_seq) begin
         j_ff <= CW'(1);
      end else if (cmd.clear_step) begin
         j_ff <= j_ff + CW'(1);
      end
      if (cmd.scan_start) begin
         i_ff <= k_eff;
      end
      if (cmd.scan_chk) begin
         if (rd_data_ff < top_sym) begin
            j_ff <= i_ff + CW'(1);
            m_ff <= '0;
         end else begin
            i_ff <= i_ff - CW'(1);
         end
      end
      // source index runs over the period, modulo i
      if (cmd.copy_wr) begin
         j_ff <= j_ff + CW'(1);
         m_ff <= (m_ff == i_idx) ? '0 : m_ff + IW'(1);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_symbol_ff <= rd_data_ff;
         rsp_last_ff   <= (rpos_ff == period_ff) && top_word_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;

   // Status to the controller
   always_comb begin
      sts.at_start   = at_start_ff;
      sts.clear_done = (j_ff == k_eff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.wrap       = (rpos_ff == period_ff);
      sts.last_word  = (rpos_ff == period_ff) && top_word_ff;
      sts.digit_less = (rd_data_ff < top_sym);
      sts.scan_first = (i_ff == CW'(1));
      sts.no_copy    = (i_ff == k_eff);
      sts.copy_done  = (j_ff == k_eff);
      sts.divisible  = (m_ff == i_idx);
   end

   `DBSG_ASSERT_ALWAYS(a_period_nonzero, clock, reset, period_ff != '0)
   `DBSG_ASSERT_ALWAYS(a_rpos_in_period, clock, reset, (rpos_ff != '0) && (rpos_ff <= period_ff))
   `DBSG_ASSERT_IMPLY(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready)
   `DBSG_ASSERT_IMPLY(a_copy_above_prefix, clock, reset, cmd.copy_wr, j_ff > i_ff)

endmodule

@@ sv/de_bruijn_sequence_generator.sv @@
// Top level of the de Bruijn sequence generator (FKM Lyndon word order).
// Depends on dbsg_pkg, dbsg_ctrl and dbsg_dpath.
//   Each request transaction (req_valid/req_ready, field req_restart) yields
//   one response transaction (rsp_valid/rsp_ready) carrying rsp_symbol and
//   rsp_last. req_restart = 1, or the first request after reset or after any
//   csr write, starts the sequence again; rsp_last marks its final symbol and
//   the next request wraps to the first symbol.
//   csr_we/csr_index/csr_wdata write the alphabet size (index 0) or the word
//   length (index 1); write them only while the block is idle.
//   Sequencing: a request is taken in the idle state; the symbol is read from
//   the digit memory in the read state and loaded into the output register
//   in the emit state, which waits until that register frees up. When the
//   period of the current word ends, the controller searches the next Lyndon
//   word before it takes another request: a read and a check state for each
//   digit scanned, a read and a write state for each digit copied, repeated
//   for each skipped prenecklace. A start of the sequence adds a clearing
//   pass over the digit memory that zeroes each digit of the word.
//   Reset is synchronous and active high. A stalled receiver holds the result
//   in the output register; one more request is taken meanwhile and waits
//   with its symbol read until the register frees up.
`timescale 1ns / 1ps

module de_bruijn_sequence_generator #(
   parameter int MAX_WORD_LENGTH = 16,
   parameter int SYMBOL_BITS     = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SYMBOL_BITS-1:0]              rsp_symbol,
   output logic                                rsp_last,
   input  logic                                csr_we,
   input  logic [dbsg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [dbsg_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   dbsg_pkg::cmd_type    cmd;
   dbsg_pkg::status_type sts;

   // Sequence controller
   dbsg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_ready   (req_ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Digit memory, counters and output register
   dbsg_dpath #(
      .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
      .SYMBOL_BITS     (SYMBOL_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last)
   );

endmodule
